FILE: design/vtdi_pkg.sv
// Package for the vertex triple dedup indexer.
// Table sizing constants, field widths and the control/status structs.
// No dependencies.
package vtdi_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 1024;
  localparam int INDEX_BITS  = 20;

  // Fixed field widths of the item payloads
  localparam int FIELD_W = 20;
  localparam int SLOT_W  = 10;

  // Derived widths
  localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int TRIPLE_W = 3 * INDEX_BITS;

  typedef logic [TRIPLE_W-1:0] triple_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;   // latch the accepted item, clear the table if asked
    logic scan;    // advance the table scan by one entry
    logic finish;  // resolve the item and load the result register
  } vtdi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;     // compared entry matches the triple
    logic miss;    // all valid entries checked, no match
  } vtdi_status_t;

endpackage

FILE: design/vtdi_if.sv
// Channel interfaces for the vertex triple dedup indexer.
// Depends on vtdi_pkg for the field widths.

// Input channel: one face corner per item
interface vtdi_in_if
  import vtdi_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               clear_table;
  logic [FIELD_W-1:0] position_index;
  logic [FIELD_W-1:0] texcoord_index;
  logic [FIELD_W-1:0] normal_index;

  modport source (
    output valid, clear_table, position_index, texcoord_index, normal_index,
    input  ready
  );
  modport sink (
    input  valid, clear_table, position_index, texcoord_index, normal_index,
    output ready
  );
endinterface

// Output channel: one result per item
interface vtdi_out_if
  import vtdi_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] unique_slot;
  logic              was_added;
  logic              overflow;

  modport source (
    output valid, unique_slot, was_added, overflow,
    input  ready
  );
  modport sink (
    input  valid, unique_slot, was_added, overflow,
    output ready
  );
endinterface

FILE: design/vertex_triple_dedup_indexer.sv
// Top level of the vertex triple dedup indexer.
// Instantiates vtdi_ctrl and vtdi_dp; uses vtdi_pkg and the channel interfaces.
//
// Each input item is one face corner (position, texcoord, normal index). The
// block searches its table of unique triples in insertion order and returns the
// slot of the first match, or appends the triple and returns the new slot. With
// clear_table set the table is emptied first. On a full table with no match the
// result has overflow set and slot 0, and nothing is stored. Items are handled
// one at a time: the single table read port checks one entry per cycle, and a
// search ends at the first match or once all stored entries are checked. A
// finished result waits in the output register; the next item is taken while
// it waits, and its own result is held back until the first is read.
module vertex_triple_dedup_indexer
  import vtdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vtdi_in_if.sink     in_ch,
  vtdi_out_if.source  out_ch
);

  vtdi_cmd_t    cmd;
  vtdi_status_t status;

  vtdi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  vtdi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .clear_table    (in_ch.clear_table),
    .position_index (in_ch.position_index),
    .texcoord_index (in_ch.texcoord_index),
    .normal_index   (in_ch.normal_index),
    .unique_slot    (out_ch.unique_slot),
    .was_added      (out_ch.was_added),
    .overflow       (out_ch.overflow)
  );

endmodule

FILE: design/vtdi_ctrl.sv
// Controller for the vertex triple dedup indexer.
// Sequences accept, scan and finish; owns the output valid flag.
// Depends on vtdi_pkg.
module vtdi_ctrl
  import vtdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  vtdi_status_t status,
  output vtdi_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;
  logic   out_free;
  logic   done;

  // Result register is free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;
  assign done     = status.hit || status.miss;
  assign in_ready = (state == ST_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd.start  = (state == ST_IDLE) && in_valid;
    cmd.finish = (state == ST_SCAN) && done && out_free;
    cmd.scan   = (state == ST_SCAN) && !done;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (done && out_free) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

FILE: design/vtdi_dp.sv
// Datapath for the vertex triple dedup indexer.
// Holds the triple table memory, entry count, scan pipeline and result register.
// Depends on vtdi_pkg.
module vtdi_dp
  import vtdi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  vtdi_cmd_t          cmd,
  output vtdi_status_t       status,
  input  logic               clear_table,
  input  logic [FIELD_W-1:0] position_index,
  input  logic [FIELD_W-1:0] texcoord_index,
  input  logic [FIELD_W-1:0] normal_index,
  output logic [SLOT_W-1:0]  unique_slot,
  output logic               was_added,
  output logic               overflow
);

  triple_t mem [TABLE_DEPTH];

  triple_t              key;
  triple_t              rd_data;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]    cmp_addr;
  logic                 cmp_valid;
  logic                 issue_ok;
  logic                 full;
  logic                 do_write;

  assign issue_ok = (rd_addr < count);
  assign full     = (count == COUNT_W'(TABLE_DEPTH));
  assign do_write = cmd.finish && !status.hit && !full;

  // Match on the entry read last cycle; miss once nothing is left to read
  assign status.hit  = cmp_valid && (rd_data == key);
  assign status.miss = !cmp_valid && !issue_ok;

  // Latch the search key from the accepted item
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= {INDEX_BITS'(position_index), INDEX_BITS'(texcoord_index),
              INDEX_BITS'(normal_index)};
    end
  end

  // Scan pipeline: issue one read per cycle, compare the entry in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr   <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.start) begin
      rd_addr   <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan) begin
      cmp_valid <= issue_ok;
      cmp_addr  <= rd_addr[ADDR_W-1:0];
      if (issue_ok) begin
        rd_addr <= rd_addr + COUNT_W'(1);
      end
    end
  end

  // Table read port
  always_ff @(posedge clk) begin
    if (cmd.scan && issue_ok) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // Table write port: append a new triple
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count[ADDR_W-1:0]] <= key;
    end
  end

  // Entry count: clear on request, advance on append
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start && clear_table) begin
      count <= '0;
    end else if (do_write) begin
      count <= count + COUNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      priority if (status.hit) begin
        unique_slot <= SLOT_W'(cmp_addr);
        was_added   <= 1'b0;
        overflow    <= 1'b0;
      end else if (!full) begin
        unique_slot <= SLOT_W'(count);
        was_added   <= 1'b1;
        overflow    <= 1'b0;
      end else begin
        unique_slot <= '0;
        was_added   <= 1'b0;
        overflow    <= 1'b1;
      end
    end
  end

endmodule

FILE: design/vtdi_checker.sv
// Port-level checker for the vertex triple dedup indexer, with its bind.
// Depends on vtdi_pkg.
module vtdi_checker
  import vtdi_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] unique_slot,
  input logic              was_added,
  input logic              overflow
);

  // Hold a result until it is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Take no second item right after one is accepted
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // Never flag an append and an overflow together
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_added && overflow))
    else $error("was_added and overflow both set");

  // Report slot zero on overflow
  assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> unique_slot == '0)
    else $error("overflow with nonzero slot");

  // Show no result in the cycle after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vertex_triple_dedup_indexer vtdi_checker u_vtdi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .unique_slot (out_ch.unique_slot),
  .was_added   (out_ch.was_added),
  .overflow    (out_ch.overflow)
);

FILE: test/vtdi_corner_checker.sv
// Scoreboard for the vertex triple dedup indexer: watches both channels,
// predicts each result from its own triple table and compares in order.
// Depends on vtdi_pkg and the vtdi_in_if / vtdi_out_if channel interfaces.
`timescale 1ns / 100ps

module vtdi_corner_checker
  import vtdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vtdi_in_if          in_ch,
  vtdi_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned n_added,
  output int unsigned n_matched,
  output int unsigned n_overflow
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              added;
    logic              ovf;
  } corner_result_t;

  // Only the low INDEX_BITS of each index take part in the compare
  localparam logic [FIELD_W-1:0] IDX_MASK = FIELD_W'((1 << INDEX_BITS) - 1);

  logic [FIELD_W-1:0] tab_pos [TABLE_DEPTH];
  logic [FIELD_W-1:0] tab_tex [TABLE_DEPTH];
  logic [FIELD_W-1:0] tab_nrm [TABLE_DEPTH];
  int unsigned        live_entries;
  corner_result_t     expected_q [$];

  // Look up one corner, append it when new, and return the expected result
  function automatic corner_result_t resolve_corner(input logic clr,
                                                    input logic [FIELD_W-1:0] p,
                                                    input logic [FIELD_W-1:0] t,
                                                    input logic [FIELD_W-1:0] n);
    corner_result_t r;
    logic [FIELD_W-1:0] pm;
    logic [FIELD_W-1:0] tm;
    logic [FIELD_W-1:0] nm;
    int unsigned scan_len;
    int hit_at;
    pm = p & IDX_MASK;
    tm = t & IDX_MASK;
    nm = n & IDX_MASK;
    if (clr) live_entries = 0;
    scan_len = (live_entries > TABLE_DEPTH) ? TABLE_DEPTH : live_entries;
    hit_at = -1;
    for (int i = 0; i < scan_len; i++) begin
      if (hit_at < 0 && tab_pos[i] == pm && tab_tex[i] == tm && tab_nrm[i] == nm)
        hit_at = i;
    end
    if (hit_at >= 0) begin
      r.slot  = SLOT_W'(hit_at);
      r.added = 1'b0;
      r.ovf   = 1'b0;
    end else if (scan_len < TABLE_DEPTH) begin
      tab_pos[scan_len] = pm;
      tab_tex[scan_len] = tm;
      tab_nrm[scan_len] = nm;
      live_entries = scan_len + 1;
      r.slot  = SLOT_W'(scan_len);
      r.added = 1'b1;
      r.ovf   = 1'b0;
    end else begin
      r.slot  = '0;
      r.added = 1'b0;
      r.ovf   = 1'b1;
    end
    return r;
  endfunction

  // Compare each accepted result with the oldest prediction, then queue new ones
  always @(posedge clk) begin
    corner_result_t want;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      expected_q.delete();
      live_entries = 0;
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no corner waiting: slot %0d added %0b overflow %0b",
                 out_ch.unique_slot, out_ch.was_added, out_ch.overflow);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.unique_slot !== want.slot) begin
            $error("unique_slot: expected %0d, got %0d", want.slot, out_ch.unique_slot);
            errs++;
          end
          if (out_ch.was_added !== want.added) begin
            $error("was_added: expected %0b, got %0b", want.added, out_ch.was_added);
            errs++;
          end
          if (out_ch.overflow !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, out_ch.overflow);
            errs++;
          end
          if (want.ovf) n_overflow <= n_overflow + 1;
          else if (want.added) n_added <= n_added + 1;
          else n_matched <= n_matched + 1;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(resolve_corner(in_ch.clear_table, in_ch.position_index,
                                            in_ch.texcoord_index, in_ch.normal_index));
      end
      outstanding <= expected_q.size();
    end
    if (errs != 0) mismatches <= mismatches + errs;
  end

endmodule

FILE: test/tb_top.sv
// Top of the vertex triple dedup indexer testbench: clock, reset, corner
// stimulus, output back-pressure, watchdog and verdict.
// Depends on vtdi_pkg, the channel interfaces, the block and vtdi_corner_checker.
`timescale 1ns / 100ps

module tb_top;
  import vtdi_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int WATCHDOG_LIMIT = 20 * (TABLE_DEPTH + 3);
  localparam int RANDOM_CORNERS = 580;
  localparam int POOL_MAX       = 24;

  logic clk;
  logic rst;
  idle_mode_t mode;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned n_added;
  int unsigned n_matched;
  int unsigned n_overflow;

  logic [FIELD_W-1:0] fill_p [TABLE_DEPTH];
  logic [FIELD_W-1:0] fill_t [TABLE_DEPTH];
  logic [FIELD_W-1:0] fill_n [TABLE_DEPTH];

  vtdi_in_if  in_ch ();
  vtdi_out_if out_ch ();

  vertex_triple_dedup_indexer uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vtdi_corner_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_added     (n_added),
    .n_matched   (n_matched),
    .n_overflow  (n_overflow)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result channel at random according to the idle pattern
  always @(posedge clk) begin
    int unsigned stall_pct;
    stall_pct = (mode == IDLE_RECV) ? 82 : (mode == IDLE_BOTH) ? 16 : 0;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no item moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one corner, after a random idle gap, and hold it until accepted
  task automatic send_corner(input logic clr, input logic [FIELD_W-1:0] p,
                             input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] n);
    int unsigned gap_pct;
    gap_pct = (mode == IDLE_SEND) ? 82 : (mode == IDLE_BOTH) ? 16 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.clear_table    <= clr;
    in_ch.position_index <= p;
    in_ch.texcoord_index <= t;
    in_ch.normal_index   <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic [FIELD_W-1:0] pool_p [POOL_MAX];
    logic [FIELD_W-1:0] pool_t [POOL_MAX];
    logic [FIELD_W-1:0] pool_n [POOL_MAX];
    logic [FIELD_W-1:0] p;
    logic [FIELD_W-1:0] t;
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] flip;
    logic clr;
    int unsigned j;
    int unsigned pick;
    int unsigned pool_size;
    int unsigned corners;
    int unsigned random_sent;
    int unsigned mesh_count;

    rst                  = 1'b1;
    mode                 = IDLE_NONE;
    quiet_cycles         = 0;
    in_ch.valid          = 1'b0;
    in_ch.clear_table    = 1'b0;
    in_ch.position_index = '0;
    in_ch.texcoord_index = '0;
    in_ch.normal_index   = '0;
    out_ch.ready         = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, one-field differences, clear mid-mesh
    send_corner(1'b1, 20'h00000, 20'h00000, 20'h00000);
    send_corner(1'b0, 20'h00000, 20'h00000, 20'h00000);
    send_corner(1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_corner(1'b0, 20'h00001, 20'h00000, 20'h00000);
    send_corner(1'b0, 20'h00000, 20'h00001, 20'h00000);
    send_corner(1'b0, 20'h00000, 20'h00000, 20'h00001);
    send_corner(1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_corner(1'b0, 20'h00001, 20'h00000, 20'h00000);
    send_corner(1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFE);
    send_corner(1'b0, 20'hA5A5A, 20'h5A5A5, 20'hA5A5A);
    send_corner(1'b0, 20'h5A5A5, 20'hA5A5A, 20'h5A5A5);
    send_corner(1'b0, 20'h00000, 20'h00000, 20'h00001);
    send_corner(1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_corner(1'b0, 20'h00000, 20'h00000, 20'h00000);
    send_corner(1'b1, 20'h00000, 20'h00000, 20'h00000);
    send_corner(1'b1, 20'h00000, 20'h00000, 20'h00000);
    send_corner(1'b0, 20'h80000, 20'h80000, 20'h80000);
    send_corner(1'b0, 20'h80000, 20'h80000, 20'h80000);

    // Fill the table to its depth with unique triples, re-sending some
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k % 256 == 0) mode = idle_mode_t'((k / 256) % 4);
      fill_p[k] = FIELD_W'($urandom);
      fill_p[k][ADDR_W-1:0] = k[ADDR_W-1:0];
      fill_t[k] = FIELD_W'($urandom);
      fill_n[k] = FIELD_W'($urandom);
      send_corner(k == 0, fill_p[k], fill_t[k], fill_n[k]);
      if ($urandom_range(7) == 0) begin
        j = $urandom_range(k);
        send_corner(1'b0, fill_p[j], fill_t[j], fill_n[j]);
      end
    end

    // Full table: hits at both ends, then random hits and overflows
    send_corner(1'b0, fill_p[TABLE_DEPTH-1], fill_t[TABLE_DEPTH-1], fill_n[TABLE_DEPTH-1]);
    send_corner(1'b0, fill_p[0], fill_t[0], fill_n[0]);
    send_corner(1'b0, ~fill_p[0], fill_t[0], fill_n[0]);
    for (int k = 0; k < 40; k++) begin
      mode = idle_mode_t'(k % 4);
      j = $urandom_range(TABLE_DEPTH - 1);
      p = fill_p[j];
      t = fill_t[j];
      n = fill_n[j];
      if ($urandom_range(1) == 0) begin
        flip = FIELD_W'(1) << $urandom_range(FIELD_W - 1);
        case ($urandom_range(2))
          0: p = p ^ flip;
          1: t = t ^ flip;
          default: n = n ^ flip;
        endcase
      end
      send_corner(1'b0, p, t, n);
    end
    // Clear a full table: the corner lands at slot 0
    send_corner(1'b1, fill_p[TABLE_DEPTH-1], fill_t[TABLE_DEPTH-1], fill_n[TABLE_DEPTH-1]);
    send_corner(1'b0, fill_p[0], fill_t[0], fill_n[0]);

    // Random meshes: corners mostly drawn from a small pool so that they repeat
    random_sent = 0;
    mesh_count  = 0;
    while (random_sent < RANDOM_CORNERS) begin
      mode      = idle_mode_t'((mesh_count / 3) % 4);
      pool_size = $urandom_range(1, POOL_MAX);
      for (int k = 0; k < pool_size; k++) begin
        pool_p[k] = FIELD_W'($urandom);
        pool_t[k] = FIELD_W'($urandom);
        pool_n[k] = FIELD_W'($urandom);
      end
      corners = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 40);
      for (int k = 0; k < corners; k++) begin
        clr  = (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(19) == 0);
        pick = $urandom_range(pool_size - 1);
        p    = pool_p[pick];
        t    = pool_t[pick];
        n    = pool_n[pick];
        flip = FIELD_W'(1) << $urandom_range(FIELD_W - 1);
        case ($urandom_range(9))
          0: begin
            p = FIELD_W'($urandom);
            t = FIELD_W'($urandom);
            n = FIELD_W'($urandom);
          end
          1: p = p ^ flip;
          2: t = t ^ flip;
          3: n = n ^ flip;
          default: ;
        endcase
        send_corner(clr, p, t, n);
        random_sent++;
      end
      mesh_count++;
    end
    in_ch.valid <= 1'b0;

    // Drain the remaining results, then allow one full scan of settling time
    mode = IDLE_NONE;
    while (outstanding != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("Checked %0d results: %0d appended, %0d matched, %0d overflowed",
             n_added + n_matched + n_overflow, n_added, n_matched, n_overflow);
    $display("Covered directed corners, one mesh filled to depth %0d and %0d random meshes",
             TABLE_DEPTH, mesh_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
